// ===== rtl/alld_pkg.sv =====
// Shared types and constants for the affinity least-load dispatcher.
// Depends on nothing; the controller, the datapath and the top level import it.
`default_nettype none

package alld_pkg;

    // Field and register widths.
    localparam int LOAD_W      = 10;
    localparam int PRIO_W      = 4;
    localparam int HOME_W      = 2;
    localparam int CPU_FIELD_W = 2;
    localparam int MASK_W      = 8;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 4;
    localparam int HOME_REG_W  = 16;

    // Threads that have a field in the priority and home registers.
    localparam int REG_THREADS = DATA_W / PRIO_W;

    localparam logic [LOAD_W-1:0] LOAD_MAX      = 10'd1023;
    localparam logic [LOAD_W-1:0] THRESH_RESET  = 10'd100;

    // Defaults for the top-level parameters.
    localparam int CPU_COUNT_DEF    = 4;
    localparam int THREAD_COUNT_DEF = 8;

    typedef enum logic [0:0] {
        CMD_SCHEDULE = 1'b0,
        CMD_FINISH   = 1'b1
    } pass_cmd_t;

    typedef enum logic [1:0] {
        REG_THRESHOLD  = 2'd0,
        REG_PRIORITIES = 2'd1,
        REG_HOME       = 2'd2
    } reg_idx_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic scan_step;
        logic thread_step;
        logic finish_op;
        logic writeback;
        logic load_out;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_schedule;
        logic in_finish;
        logic scan_last;
        logic thread_last;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/affinity_least_load_dispatch.sv =====
// Top level of the affinity least-load dispatcher: configuration registers,
// APB-style port, controller and datapath. Depends on alld_pkg, alld_ctrl, alld_dp.
//
// Usage. One input transfer (command, cpu_index) runs one pass for a CPU and
// yields exactly one result transfer (thread_mask, cpu_load). A schedule pass
// first scans all CPU loads, one CPU per cycle, then walks the threads in
// index order, one thread per cycle, because each placement changes the load
// that the next thread sees. A finish pass needs a single work state.
// A pass for a CPU outside CPU_COUNT does no work. Each pass ends in a done
// state that waits while the output register still holds an untaken result;
// the result is then loaded into the output register, and out_valid rises,
// at the same edge at which in_ready is high again.
// The result sits in an output register, so a new input transfer is taken
// while the previous result still waits; only a second finished result is
// held back, with in_ready low, until the receiver takes the first one.
// Reset (rst_n low, asynchronous) clears all loads and running flags, loads
// every thread's last CPU from the home register (zero) and sets the threshold
// to 100. Registers should be written only while no pass is in flight; a write
// to the home register reloads every thread's last CPU.
`default_nettype none

module affinity_least_load_dispatch
    import alld_pkg::*;
#(
    parameter int CPU_COUNT    = CPU_COUNT_DEF,
    parameter int THREAD_COUNT = THREAD_COUNT_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    // Pass requests.
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   command,
    input  wire logic [CPU_FIELD_W-1:0] cpu_index,

    // Pass results.
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [MASK_W-1:0]           thread_mask,
    output logic [LOAD_W-1:0]           cpu_load,

    // Configuration port.
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [ADDR_W-1:0]      paddr,
    input  wire logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]           prdata,
    output logic                        pready
);

    logic [LOAD_W-1:0]     threshold_reg;
    logic [DATA_W-1:0]     priorities_reg;
    logic [HOME_REG_W-1:0] home_reg;
    logic                  cfg_write;
    logic                  home_write;
    reg_idx_t              reg_idx;
    dp_cmd_t               dp_cmd;
    dp_status_t            dp_status;

    // The port never inserts wait states; a write lands on the access cycle.
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign reg_idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign home_write = cfg_write && (reg_idx == REG_HOME);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESH_RESET;
            priorities_reg <= '0;
            home_reg       <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_THRESHOLD:  threshold_reg  <= pwdata[LOAD_W-1:0];
                REG_PRIORITIES: priorities_reg <= pwdata;
                REG_HOME:       home_reg       <= pwdata[HOME_REG_W-1:0];
                default:        ;
            endcase
        end
    end

    // Reads return the stored value; addresses past the last register read zero.
    always_comb
    begin
        case (reg_idx)
            REG_THRESHOLD:  prdata = {{(DATA_W - LOAD_W){1'b0}}, threshold_reg};
            REG_PRIORITIES: prdata = priorities_reg;
            REG_HOME:       prdata = {{(DATA_W - HOME_REG_W){1'b0}}, home_reg};
            default:        prdata = '0;
        endcase
    end

    alld_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    // The home value reaches the datapath straight from pwdata so that the
    // last-CPU store reloads on the same edge as the register itself.
    alld_dp #(
        .CPU_COUNT    (CPU_COUNT),
        .THREAD_COUNT (THREAD_COUNT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .command     (command),
        .cpu_index   (cpu_index),
        .threshold   (threshold_reg),
        .priorities  (priorities_reg),
        .homes       (pwdata[HOME_REG_W-1:0]),
        .home_write  (home_write),
        .cmd         (dp_cmd),
        .status      (dp_status),
        .thread_mask (thread_mask),
        .cpu_load    (cpu_load)
    );

endmodule

`default_nettype wire

// ===== rtl/alld_ctrl.sv =====
// Sequencing state machine for the dispatcher.
// Depends on alld_pkg; drives the datapath through dp_cmd_t and reads dp_status_t.
`default_nettype none

module alld_ctrl
    import alld_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_THREAD,
        ST_WB,
        ST_FIN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    if (status.in_schedule)
                        state_next = ST_SCAN;
                    else if (status.in_finish)
                        state_next = ST_FIN;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                    state_next = ST_THREAD;
            end
            ST_THREAD:
            begin
                cmd.thread_step = 1'b1;
                if (status.thread_last)
                    state_next = ST_WB;
            end
            ST_WB:
            begin
                cmd.writeback = 1'b1;
                state_next    = ST_DONE;
            end
            ST_FIN:
            begin
                cmd.finish_op = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A new result appears only when a pass has reached its last state.
    a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done state");

    // The thread walk always closes with a load write-back.
    a_thread_to_wb: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_THREAD && status.thread_last) |=> (state_reg == ST_WB))
        else $error("thread walk did not end in write-back");

    // Without a transfer the controller stays idle.
    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !in_valid) |=> (state_reg == ST_IDLE))
        else $error("left idle without an input transfer");

endmodule

`default_nettype wire

// ===== rtl/alld_dp.sv =====
// Datapath of the dispatcher: CPU loads, running flags, last-CPU store,
// the per-pass scan and thread walk, and the result register. Depends on alld_pkg.
`default_nettype none

module alld_dp
    import alld_pkg::*;
#(
    parameter int CPU_COUNT    = CPU_COUNT_DEF,
    parameter int THREAD_COUNT = THREAD_COUNT_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   command,
    input  wire logic [CPU_FIELD_W-1:0] cpu_index,
    input  wire logic [LOAD_W-1:0]      threshold,
    input  wire logic [DATA_W-1:0]      priorities,
    input  wire logic [HOME_REG_W-1:0]  homes,
    input  wire logic                   home_write,
    input  wire dp_cmd_t                cmd,
    output dp_status_t                  status,
    output logic [MASK_W-1:0]           thread_mask,
    output logic [LOAD_W-1:0]           cpu_load
);

    localparam int CW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int TW = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;

    // Architectural state.
    logic [LOAD_W-1:0]      loads_reg [CPU_COUNT];
    logic [THREAD_COUNT-1:0] running_reg;
    logic [HOME_W-1:0]      last_reg [THREAD_COUNT];

    // Per-pass working registers.
    logic [CPU_FIELD_W-1:0] cpu_reg;
    logic [CW-1:0]          scan_idx_reg;
    logic [TW-1:0]          thr_idx_reg;
    logic [CPU_COUNT-1:0]   below_reg;
    logic                   omin_valid_reg;
    logic [LOAD_W-1:0]      acc_reg;
    logic [LOAD_W-1:0]      omin_reg;
    logic [CW-1:0]          omin_idx_reg;
    logic [MASK_W-1:0]      mask_reg;
    logic [MASK_W-1:0]      thread_mask_reg;
    logic [LOAD_W-1:0]      cpu_load_reg;

    logic [31:0]             cpu_in_wide;
    logic [31:0]             cpu_reg_wide;
    logic [LOAD_W-1:0]       scan_load;
    logic                    scan_is_cpu;
    logic [LOAD_W-1:0]       dec_load;
    logic [PRIO_W-1:0]       prio_vec [THREAD_COUNT];
    logic [HOME_W-1:0]       home_vec [THREAD_COUNT];
    logic [THREAD_COUNT-1:0] release_vec;
    logic [MASK_W-1:0]       release_mask;
    logic [MASK_W-1:0]       hit_mask;
    logic [HOME_W-1:0]       last_t;
    logic [31:0]             last_wide;
    logic                    last_in_range;
    logic                    last_is_cpu;
    logic                    keep;
    logic                    least_is_cpu;
    logic                    hit;
    logic [LOAD_W:0]         sum;
    logic [LOAD_W-1:0]       sat_sum;

    assign cpu_in_wide  = 32'(cpu_index);
    assign cpu_reg_wide = 32'(cpu_reg);

    assign status.in_schedule = (cpu_in_wide < CPU_COUNT) && (command == CMD_SCHEDULE);
    assign status.in_finish   = (cpu_in_wide < CPU_COUNT) && (command == CMD_FINISH);
    assign status.scan_last   = (32'(scan_idx_reg) == CPU_COUNT - 1);
    assign status.thread_last = (32'(thr_idx_reg) == THREAD_COUNT - 1);

    // Register fields per thread; threads past the register fields read zero.
    for (genvar t = 0; t < THREAD_COUNT; t++)
    begin : g_thread
        if (t < REG_THREADS)
        begin : g_field
            assign prio_vec[t] = priorities[PRIO_W*t +: PRIO_W];
            assign home_vec[t] = homes[HOME_W*t +: HOME_W];
        end
        else
        begin : g_zero
            assign prio_vec[t] = '0;
            assign home_vec[t] = '0;
        end
        assign release_vec[t] = running_reg[t] && (last_reg[t] == cpu_reg);
    end

    for (genvar i = 0; i < MASK_W; i++)
    begin : g_mask
        if (i < THREAD_COUNT)
        begin : g_live
            assign release_mask[i] = release_vec[i];
            assign hit_mask[i]     = hit && (32'(thr_idx_reg) == i);
        end
        else
        begin : g_dead
            assign release_mask[i] = 1'b0;
            assign hit_mask[i]     = 1'b0;
        end
    end

    // One load is read per cycle, at the scan index. For a finish pass the
    // scan index is parked on the acting CPU.
    assign scan_load   = loads_reg[scan_idx_reg];
    assign scan_is_cpu = (32'(scan_idx_reg) == cpu_reg_wide);
    assign dec_load    = (scan_load == '0) ? '0 : scan_load - 1'b1;

    // Placement of the current thread. Loads of the other CPUs do not move
    // during a schedule pass, so their minimum and their below-threshold
    // flags come from the scan; the acting CPU's load lives in acc_reg.
    assign last_t        = last_reg[thr_idx_reg];
    assign last_wide     = 32'(last_t);
    assign last_in_range = (last_wide < CPU_COUNT);
    assign last_is_cpu   = (last_t == cpu_reg);
    assign keep          = last_in_range &&
                           (last_is_cpu ? (acc_reg < threshold) : below_reg[last_wide[CW-1:0]]);
    assign least_is_cpu  = !omin_valid_reg || (acc_reg < omin_reg) ||
                           ((acc_reg == omin_reg) && (cpu_reg_wide < 32'(omin_idx_reg)));
    assign hit           = cmd.thread_step && !running_reg[thr_idx_reg] &&
                           (keep ? last_is_cpu : least_is_cpu);

    assign sum     = {1'b0, acc_reg} + {{(LOAD_W + 1 - PRIO_W){1'b0}}, prio_vec[thr_idx_reg]};
    assign sat_sum = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];

    // State that reset defines.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CPU_COUNT; c++)
                loads_reg[c] <= '0;
            for (int t = 0; t < THREAD_COUNT; t++)
                last_reg[t] <= '0;
            running_reg    <= '0;
            cpu_reg        <= '0;
            scan_idx_reg   <= '0;
            thr_idx_reg    <= '0;
            below_reg      <= '0;
            omin_valid_reg <= 1'b0;
        end
        else
        begin
            if (home_write)
            begin
                for (int t = 0; t < THREAD_COUNT; t++)
                    last_reg[t] <= home_vec[t];
            end

            if (cmd.capture)
            begin
                cpu_reg        <= cpu_index;
                scan_idx_reg   <= (command == CMD_FINISH) ? cpu_in_wide[CW-1:0] : '0;
                thr_idx_reg    <= '0;
                omin_valid_reg <= 1'b0;
            end

            if (cmd.scan_step)
            begin
                below_reg[scan_idx_reg] <= (scan_load < threshold);
                if (!scan_is_cpu && (!omin_valid_reg || scan_load < omin_reg))
                    omin_valid_reg <= 1'b1;
                scan_idx_reg <= status.scan_last ? '0 : scan_idx_reg + 1'b1;
            end

            if (cmd.thread_step)
            begin
                if (hit)
                begin
                    running_reg[thr_idx_reg] <= 1'b1;
                    last_reg[thr_idx_reg]    <= cpu_reg;
                end
                thr_idx_reg <= status.thread_last ? '0 : thr_idx_reg + 1'b1;
            end

            if (cmd.finish_op)
            begin
                loads_reg[scan_idx_reg] <= dec_load;
                running_reg             <= running_reg & ~release_vec;
            end

            if (cmd.writeback)
                loads_reg[cpu_reg_wide[CW-1:0]] <= acc_reg;
        end
    end

    // Working values that need no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            acc_reg  <= '0;
            mask_reg <= '0;
        end

        if (cmd.scan_step)
        begin
            if (scan_is_cpu)
                acc_reg <= scan_load;
            else if (!omin_valid_reg || scan_load < omin_reg)
            begin
                omin_reg     <= scan_load;
                omin_idx_reg <= scan_idx_reg;
            end
        end

        if (hit)
        begin
            acc_reg  <= sat_sum;
            mask_reg <= mask_reg | hit_mask;
        end

        if (cmd.finish_op)
        begin
            acc_reg  <= dec_load;
            mask_reg <= release_mask;
        end

        if (cmd.load_out)
        begin
            thread_mask_reg <= mask_reg;
            cpu_load_reg    <= acc_reg;
        end
    end

    assign thread_mask = thread_mask_reg;
    assign cpu_load    = cpu_load_reg;

    // After a finish pass no running thread is left on the acting CPU.
    a_finish_releases: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.finish_op) |-> (release_vec == '0))
        else $error("running thread left on the finished CPU");

    // The acting load never drops while threads are being placed.
    a_acc_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.thread_step |=> (acc_reg >= $past(acc_reg)))
        else $error("acting load dropped during the thread walk");

endmodule

`default_nettype wire
